/* rtl/small_matrix_operation_engine_top_assert.svh */
// Assertion macros for the matrix engine. Each macro checks a clocked
// implication on i_clk, ignored while reset is held.
`ifndef SMALL_MATRIX_OPERATION_ENGINE_TOP_ASSERT_SVH
`define SMALL_MATRIX_OPERATION_ENGINE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SME_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sme_pkg.sv */
`default_nettype none

package sme_pkg;

    localparam int ELEM_W    = 32;
    localparam int CFG_W     = 5;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TRA = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TRB = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd2;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

endpackage

`default_nettype wire

/* rtl/sme_ram.sv */
`default_nettype none

// Single-port-write, single-port-read synchronous RAM with a registered read.
module sme_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [ADDR_W-1:0]         i_waddr,
    input  wire logic [sme_pkg::ELEM_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0]         i_raddr,
    output logic      [sme_pkg::ELEM_W-1:0] o_rdata
);

    logic [sme_pkg::ELEM_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/small_matrix_operation_engine_top.sv */
// Integer matrix engine. Load requests (action 0) fill matrix A and then
// matrix B in row-major order, one element per cycle while idle, for the
// size given by row_count and col_count; loads beyond both are dropped. Fetch
// requests (action 1) each return one element of the op_mode result (add,
// subtract, multiply, transpose A, transpose B) in row-major order, with
// last_element on the final element, after which the sequence starts over.
// All arithmetic wraps at 32 bits. A fetch before loading is complete, an
// unknown mode, or a multiply of a non-square size returns an error element.
// Writing a dimension restarts loading and fetching; writing op_mode
// restarts fetching. Configuration must only be written while idle.
// A load is written at the edge that takes it. An add, subtract or transpose
// fetch reads both RAMs, the evaluate state registers the result and the done
// state hands it on. A multiply fetch uses the single shared multiplier, which
// consumes one A/B element pair per cycle from the two element RAMs. The output
// register lets the next request be taken while a result waits to be picked up.
`default_nettype none

`include "small_matrix_operation_engine_top_assert.svh"

module small_matrix_operation_engine_top #(
    parameter int MAX_DIM = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Configuration write port.
    input  wire logic                               i_cfg_we,
    input  wire logic [sme_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [sme_pkg::CFG_W-1:0]          i_cfg_data,
    // Request channel.
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_action,
    input  wire logic signed [sme_pkg::ELEM_W-1:0]  i_element_value,
    // Result channel.
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed [sme_pkg::ELEM_W-1:0]       o_result_value,
    output logic                                    o_last_element,
    output logic                                    o_error_flag
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int N_W    = $clog2(DEPTH + 1);
    localparam int CNT_W  = $clog2(2 * DEPTH + 1);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int EW     = sme_pkg::ELEM_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // A dimension of zero counts as one, and one above MAX_DIM as MAX_DIM.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [sme_pkg::CFG_W-1:0] d);
        logic [DIM_W-1:0] v;
        if (d == '0) begin
            v = DIM_W'(1);
        end else if (int'(d) > MAX_DIM) begin
            v = DIM_W'(MAX_DIM);
        end else begin
            v = DIM_W'(d);
        end
        return v;
    endfunction

    // Configuration registers.
    logic [sme_pkg::MODE_W-1:0] r_op_mode;
    logic [sme_pkg::CFG_W-1:0]  r_row_count;
    logic [sme_pkg::CFG_W-1:0]  r_col_count;

    // Load and fetch positions. The fetch position is kept as a linear
    // index plus its inner and outer coordinates and the derived source
    // addresses, so no division is ever needed.
    logic [CNT_W-1:0]  r_lpos;
    logic [ADDR_W-1:0] r_fpos;
    logic [IDX_W-1:0]  r_fi;
    logic [IDX_W-1:0]  r_fj;
    logic [ADDR_W-1:0] r_fsrc;     // transpose source address j*cols + i
    logic [ADDR_W-1:0] r_rowbase;  // start of row i of A, i*cols

    // Sequencer and multiply datapath.
    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [DIM_W-1:0]  r_k;
    logic [ADDR_W-1:0] r_a_addr;
    logic [ADDR_W-1:0] r_b_addr;
    logic              r_rd_vld;
    logic              r_prod_vld;
    logic [EW-1:0]     r_prod;
    logic [EW-1:0]     r_acc;

    // Finished result waiting for the output register.
    logic [EW-1:0]     r_res;
    logic              r_res_last;
    logic              r_res_err;

    // Output register.
    logic              r_o_valid;
    logic [EW-1:0]     r_o_value;
    logic              r_o_last;
    logic              r_o_err;

    logic [DIM_W-1:0]  w_rows;
    logic [DIM_W-1:0]  w_cols;
    logic [DIM_W-1:0]  w_inner;
    logic [N_W-1:0]    w_n;
    logic [CNT_W-1:0]  w_2n;
    logic              w_in_acc;
    logic              w_load;
    logic              w_fetch;
    logic              w_err;
    logic              w_last;
    logic              w_inner_wrap;
    logic              w_issue;
    logic              w_mul_end;
    logic              w_out_free;
    logic              w_cfg_dim;
    logic              w_a_we;
    logic              w_b_we;
    logic [ADDR_W-1:0] w_b_waddr;
    logic [ADDR_W-1:0] w_a_raddr;
    logic [ADDR_W-1:0] w_b_raddr;
    logic [EW-1:0]     w_a_rdata;
    logic [EW-1:0]     w_b_rdata;
    logic [2*EW-1:0]   w_prod_full;
    logic [EW-1:0]     w_eval;

    assign w_rows  = eff_dim(r_row_count);
    assign w_cols  = eff_dim(r_col_count);
    assign w_n     = N_W'(w_rows) * N_W'(w_cols);
    assign w_2n    = CNT_W'(w_n) << 1;
    // Transposed results step over the source rows first, then the columns.
    assign w_inner = (r_op_mode == sme_pkg::MODE_TRA || r_op_mode == sme_pkg::MODE_TRB)
                     ? w_rows : w_cols;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_load     = w_in_acc && (i_action == sme_pkg::ACT_LOAD);
    assign w_fetch    = w_in_acc && (i_action == sme_pkg::ACT_FETCH);
    assign w_cfg_dim  = i_cfg_we && (i_cfg_index == sme_pkg::CFG_ROW_COUNT ||
                                     i_cfg_index == sme_pkg::CFG_COL_COUNT);

    assign w_err = (r_lpos < w_2n) || (r_op_mode > sme_pkg::MODE_TRB) ||
                   (r_op_mode == sme_pkg::MODE_MUL && w_rows != w_cols);
    assign w_last       = (N_W'(r_fpos) + N_W'(1)) == w_n;
    assign w_inner_wrap = (DIM_W'(r_fj) + DIM_W'(1)) == w_inner;

    // Loads fill A for the first n positions and B for the next n.
    assign w_a_we    = w_load && (r_lpos < CNT_W'(w_n));
    assign w_b_we    = w_load && !(r_lpos < CNT_W'(w_n)) && (r_lpos < w_2n);
    assign w_b_waddr = ADDR_W'(r_lpos - CNT_W'(w_n));

    // Reads are issued at the fetch request edge, and each cycle of a
    // multiply. Loads write only in the idle state on requests of their
    // own, so a read and a write never meet on the same entry.
    always_comb begin
        if (r_state == ST_MUL) begin
            w_a_raddr = r_a_addr;
            w_b_raddr = r_b_addr;
        end else begin
            case (r_op_mode)
                sme_pkg::MODE_MUL: begin
                    w_a_raddr = r_rowbase;
                    w_b_raddr = ADDR_W'(r_fj);
                end
                sme_pkg::MODE_TRA,
                sme_pkg::MODE_TRB: begin
                    w_a_raddr = r_fsrc;
                    w_b_raddr = r_fsrc;
                end
                default: begin
                    w_a_raddr = r_fpos;
                    w_b_raddr = r_fpos;
                end
            endcase
        end
    end

    sme_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (r_lpos[ADDR_W-1:0]),
        .i_wdata ($unsigned(i_element_value)),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_rdata)
    );

    sme_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_b_waddr),
        .i_wdata ($unsigned(i_element_value)),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rdata)
    );

    // Multiply pipeline: read pair, registered product, accumulate.
    assign w_issue     = (r_state == ST_MUL) && (r_k < w_cols);
    assign w_mul_end   = (r_state == ST_MUL) && !w_issue && !r_rd_vld && !r_prod_vld;
    assign w_prod_full = w_a_rdata * w_b_rdata;

    always_comb begin
        case (r_op_mode)
            sme_pkg::MODE_ADD: w_eval = w_a_rdata + w_b_rdata;
            sme_pkg::MODE_SUB: w_eval = w_a_rdata - w_b_rdata;
            sme_pkg::MODE_TRA: w_eval = w_a_rdata;
            sme_pkg::MODE_TRB: w_eval = w_b_rdata;
            default:           w_eval = '0;
        endcase
    end

    assign w_out_free = !r_o_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_fetch) begin
                    if (w_err) begin
                        n_state = ST_DONE;
                    end else if (r_op_mode == sme_pkg::MODE_MUL) begin
                        n_state = ST_MUL;
                    end else begin
                        n_state = ST_EVAL;
                    end
                end
            end
            ST_EVAL: n_state = ST_DONE;
            ST_MUL: begin
                if (w_mul_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state: configuration, positions, sequencer, valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode   <= sme_pkg::MODE_ADD;
            r_row_count <= sme_pkg::CFG_W'(1);
            r_col_count <= sme_pkg::CFG_W'(1);
            r_lpos      <= '0;
            r_fpos      <= '0;
            r_fi        <= '0;
            r_fj        <= '0;
            r_fsrc      <= '0;
            r_rowbase   <= '0;
            r_state     <= ST_IDLE;
            r_rd_vld    <= 1'b0;
            r_prod_vld  <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_prod_vld <= r_rd_vld;
            if (w_fetch) begin
                r_rd_vld <= !w_err && (r_op_mode == sme_pkg::MODE_MUL);
            end else begin
                r_rd_vld <= w_issue;
            end

            if (w_a_we || w_b_we) begin
                r_lpos <= r_lpos + CNT_W'(1);
            end

            // Step the fetch position once per successful fetch.
            if (w_fetch && !w_err) begin
                if (w_last) begin
                    r_fpos    <= '0;
                    r_fi      <= '0;
                    r_fj      <= '0;
                    r_fsrc    <= '0;
                    r_rowbase <= '0;
                end else begin
                    r_fpos <= r_fpos + ADDR_W'(1);
                    if (w_inner_wrap) begin
                        r_fj      <= '0;
                        r_fi      <= r_fi + IDX_W'(1);
                        r_fsrc    <= ADDR_W'(r_fi) + ADDR_W'(1);
                        r_rowbase <= r_rowbase + ADDR_W'(w_cols);
                    end else begin
                        r_fj   <= r_fj + IDX_W'(1);
                        r_fsrc <= r_fsrc + ADDR_W'(w_cols);
                    end
                end
            end

            // Configuration writes restart the sequences they affect.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sme_pkg::CFG_OP_MODE: begin
                        r_op_mode <= i_cfg_data[sme_pkg::MODE_W-1:0];
                    end
                    sme_pkg::CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                    sme_pkg::CFG_COL_COUNT: r_col_count <= i_cfg_data;
                    default: ;
                endcase
                if (w_cfg_dim) begin
                    r_lpos <= '0;
                end
                if (w_cfg_dim || i_cfg_index == sme_pkg::CFG_OP_MODE) begin
                    r_fpos    <= '0;
                    r_fi      <= '0;
                    r_fj      <= '0;
                    r_fsrc    <= '0;
                    r_rowbase <= '0;
                end
            end

            if (r_state == ST_DONE && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_fetch) begin
            r_k        <= DIM_W'(1);
            r_a_addr   <= r_rowbase + ADDR_W'(1);
            r_b_addr   <= ADDR_W'(r_fj) + ADDR_W'(w_cols);
            r_acc      <= '0;
            r_res_last <= !w_err && w_last;
            r_res_err  <= w_err;
            r_res      <= '0;
        end
        if (w_issue) begin
            r_k      <= r_k + DIM_W'(1);
            r_a_addr <= r_a_addr + ADDR_W'(1);
            r_b_addr <= r_b_addr + ADDR_W'(w_cols);
        end
        if (r_rd_vld) begin
            r_prod <= w_prod_full[EW-1:0];
        end
        if (r_prod_vld) begin
            r_acc <= r_acc + r_prod;
        end
        if (r_state == ST_EVAL) begin
            r_res <= w_eval;
        end
        if (w_mul_end) begin
            r_res <= r_acc;
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_o_value <= r_res;
            r_o_last  <= r_res_last;
            r_o_err   <= r_res_err;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_result_value = $signed(r_o_value);
    assign o_last_element = r_o_last;
    assign o_error_flag   = r_o_err;

    // A fetch that cannot be served goes straight to delivery as an error.
    `SME_ASSERT_NEXT(a_fetch_error_path, w_fetch && w_err, r_state == ST_DONE && r_res_err, "error fetch did not go to delivery")
    // The fetch position always lies inside the current result matrix.
    `SME_ASSERT_NOW(a_fetch_pos_range, 1'b1, N_W'(r_fpos) < w_n, "fetch position beyond result size")
    // The load position never passes the end of matrix B.
    `SME_ASSERT_NOW(a_load_pos_range, 1'b1, r_lpos <= w_2n, "load position beyond both matrices")

endmodule

`default_nettype wire

/* tb/sme_result_checker.sv */
`default_nettype none

module sme_result_checker #(
    parameter int MAX_DIM = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [sme_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [sme_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire logic                               i_in_valid,
    input  wire logic                               i_in_stall,
    input  wire logic                               i_action,
    input  wire logic signed [sme_pkg::ELEM_W-1:0]  i_element_value,
    input  wire logic                               i_out_valid,
    input  wire logic                               i_out_stall,
    input  wire logic signed [sme_pkg::ELEM_W-1:0]  i_result_value,
    input  wire logic                               i_last_element,
    input  wire logic                               i_error_flag,
    output int                                      o_fail_count,
    output int                                      o_pending
);

    import sme_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [ELEM_W-1:0] value;
        logic                     last;
        logic                     err_flag;
    } matrix_element_t;

    logic [MODE_W-1:0] mode_reg;
    logic [CFG_W-1:0]  rows_reg;
    logic [CFG_W-1:0]  cols_reg;
    logic [ELEM_W-1:0] a_store [DEPTH];
    logic [ELEM_W-1:0] b_store [DEPTH];
    int                load_pos;
    int                fetch_pos;
    matrix_element_t   element_q [$];

    // Out-of-range sizes are folded into 1..MAX_DIM.
    function automatic int clamp_dim(input logic [CFG_W-1:0] dim);
        if (dim == 0) return 1;
        if (dim > MAX_DIM) return MAX_DIM;
        return int'(dim);
    endfunction

    task automatic compute_element(input logic act, input logic [ELEM_W-1:0] elem);
        int              rows;
        int              cols;
        int              total;
        int              pos;
        int              r;
        int              c;
        logic [ELEM_W-1:0] acc;
        matrix_element_t res;
        rows = clamp_dim(rows_reg);
        cols = clamp_dim(cols_reg);
        total = rows * cols;
        if (act == ACT_LOAD) begin
            // Loads fill A, then B; anything beyond both is dropped.
            if (load_pos < total) begin
                a_store[ADDR_W'(load_pos)] = elem;
                load_pos++;
            end else if (load_pos < 2 * total) begin
                b_store[ADDR_W'(load_pos - total)] = elem;
                load_pos++;
            end
            return;
        end
        res = '0;
        res.err_flag = 1'b1;
        if (load_pos >= 2 * total && mode_reg <= MODE_TRB &&
            !(mode_reg == MODE_MUL && rows != cols)) begin
            if (fetch_pos >= total) fetch_pos = 0;
            pos = fetch_pos;
            acc = '0;
            case (mode_reg)
                MODE_ADD: acc = a_store[ADDR_W'(pos)] + b_store[ADDR_W'(pos)];
                MODE_SUB: acc = a_store[ADDR_W'(pos)] - b_store[ADDR_W'(pos)];
                MODE_MUL: begin
                    r = pos / cols;
                    c = pos % cols;
                    for (int k = 0; k < cols; k++) begin
                        acc = acc + a_store[ADDR_W'(r * cols + k)] *
                                    b_store[ADDR_W'(k * cols + c)];
                    end
                end
                // The transposed result is cols x rows.
                MODE_TRA: acc = a_store[ADDR_W'((pos % rows) * cols + pos / rows)];
                default:  acc = b_store[ADDR_W'((pos % rows) * cols + pos / rows)];
            endcase
            res.value = acc;
            res.last = (pos + 1 == total);
            res.err_flag = 1'b0;
            fetch_pos = res.last ? 0 : pos + 1;
        end
        element_q.push_back(res);
    endtask

    task automatic check_element(input matrix_element_t got);
        matrix_element_t want;
        if (element_q.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= REPORT_LIMIT) begin
                $display("%0t: result with nothing expected: value %h last %b error %b",
                         $realtime, got.value, got.last, got.err_flag);
            end
            return;
        end
        want = element_q.pop_front();
        if (got.value !== want.value || got.last !== want.last ||
            got.err_flag !== want.err_flag) begin
            o_fail_count++;
            if (o_fail_count <= REPORT_LIMIT) begin
                $display("%0t: mismatch: expected value %h last %b error %b, got value %h last %b error %b",
                         $realtime, want.value, want.last, want.err_flag,
                         got.value, got.last, got.err_flag);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_reg = MODE_ADD;
            rows_reg = CFG_W'(1);
            cols_reg = CFG_W'(1);
            load_pos = 0;
            fetch_pos = 0;
            element_q.delete();
        end else begin
            // A result leaving now belongs to an earlier request, so it is
            // checked before any request taken at the same edge is predicted.
            if (i_out_valid && !i_out_stall) begin
                check_element({i_result_value, i_last_element, i_error_flag});
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OP_MODE: begin
                        mode_reg = i_cfg_data[MODE_W-1:0];
                        fetch_pos = 0;
                    end
                    CFG_ROW_COUNT: begin
                        rows_reg = i_cfg_data;
                        load_pos = 0;
                        fetch_pos = 0;
                    end
                    CFG_COL_COUNT: begin
                        cols_reg = i_cfg_data;
                        load_pos = 0;
                        fetch_pos = 0;
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                compute_element(i_action, i_element_value);
            end
        end
        o_pending = element_q.size();
    end

endmodule

`default_nettype wire

/* tb/small_matrix_operation_engine_top_tb.sv */
`default_nettype none

// Stimulus and verdict for the matrix engine. The checker instance beside the
// block watches both channels, predicts every result and counts failures;
// this module only drives requests, configuration and the result stall.
module small_matrix_operation_engine_top_tb;

    import sme_pkg::*;

    localparam int MAX_DIM = 16;
    // The settle time outlasts the longest multiply, so this covers any work
    // still in flight after a load-only tail.
    localparam int SETTLE_CYCLES = MAX_DIM + 8;
    localparam int RANDOM_REQUESTS = 120;
    localparam int FETCH_RUN_CAP = 40;
    localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_ALTERNATE
    } stall_style_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = CFG_OP_MODE;
    logic [CFG_W-1:0]         cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     action = ACT_LOAD;
    logic signed [ELEM_W-1:0] element_value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [ELEM_W-1:0] result_value;
    logic                     last_element;
    logic                     error_flag;
    int                       fail_count;
    int                       pending;

    // Sender bookkeeping: requests left in the current burst, requests taken
    // so far, and the effective size last written, for mode-only phases.
    int requests_sent = 0;
    int burst_left = 0;
    int cur_rows = 1;
    int cur_cols = 1;

    // Receiver stall pattern state.
    stall_style_t stall_style = STALL_NONE;
    int           style_left = 0;
    int           stall_phase = 0;

    always #4 clk = ~clk;

    small_matrix_operation_engine_top #(
        .MAX_DIM(MAX_DIM)
    ) u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_action       (action),
        .i_element_value(element_value),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_result_value (result_value),
        .o_last_element (last_element),
        .o_error_flag   (error_flag)
    );

    sme_result_checker #(
        .MAX_DIM(MAX_DIM)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_action       (action),
        .i_element_value(element_value),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_result_value (result_value),
        .i_last_element (last_element),
        .i_error_flag   (error_flag),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // The receiver switches at random between four stall styles:
    // never stalling, stalling now and then, stalling most of the time, and
    // a regular on/off rhythm. Results therefore wait out stalls of every
    // length, and some stretches run with no stall at all.
    always @(negedge clk) begin
        if (style_left == 0) begin
            stall_style = stall_style_t'($urandom_range(0, 3));
            style_left = $urandom_range(16, 96);
        end
        style_left--;
        stall_phase++;
        case (stall_style)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= stall_phase[1];
        endcase
    end

    // Hard limit on the run, far beyond the slowest correct run.
    initial begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // All tasks below start and end at a falling edge, where inputs change.

    // One register write; the block takes it at the next rising edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Offers one request and holds it until it is taken. Requests go out in
    // bursts; between bursts valid drops for a random gap, which is sometimes
    // zero so that long runs go back to back.
    task automatic send_request(input logic act, input logic [ELEM_W-1:0] elem);
        int gap;
        if (burst_left == 0) begin
            in_valid = 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        in_valid = 1'b1;
        action = act;
        element_value = elem;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        burst_left--;
        requests_sent++;
    endtask

    // The sender pauses until every expected result has arrived, then lets
    // the block settle so that configuration can be written safely.
    task automatic wait_for_results();
        in_valid = 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Element values lean toward the extremes of the signed range.
    function automatic logic [ELEM_W-1:0] random_element();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return ELEM_MAX;
            3:       return ELEM_MIN;
            4:       return 1;
            default: return $urandom();
        endcase
    endfunction

    // Mostly small sizes keep the load sequences short; a zero or an
    // oversized value exercises the folding of out-of-range sizes.
    function automatic logic [CFG_W-1:0] random_dim();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 82) return CFG_W'($urandom_range(1, 4));
        if (pick < 90) return '0;
        if (pick < 97) return CFG_W'($urandom_range(5, 8));
        return CFG_W'($urandom_range(MAX_DIM + 1, (1 << CFG_W) - 1));
    endfunction

    function automatic int effective_dim(input logic [CFG_W-1:0] dim);
        if (dim == 0) return 1;
        if (dim > MAX_DIM) return MAX_DIM;
        return int'(dim);
    endfunction

    // One phase: new configuration while idle, a load sequence, a run of
    // fetches, then a full drain. Most phases load both matrices completely
    // so that fetches reach the arithmetic; a few stop loading early, and a
    // sprinkling of stray requests adds early fetches and ignored loads.
    task automatic run_random_phase();
        int                pick;
        int                total;
        int                loads;
        int                fetches;
        logic [CFG_W-1:0]  row_cfg;
        logic [CFG_W-1:0]  col_cfg;
        logic [MODE_W-1:0] mode_cfg;
        pick = $urandom_range(0, 99);
        if (pick < 90) begin
            mode_cfg = MODE_W'($urandom_range(MODE_ADD, MODE_TRB));
        end else begin
            mode_cfg = MODE_W'($urandom_range(MODE_TRB + 1, (1 << MODE_W) - 1));
        end
        loads = 0;
        if ($urandom_range(0, 99) < 15) begin
            // Only the mode changes: the loaded matrices stay, fetching
            // restarts from the first element.
            write_reg(CFG_OP_MODE, CFG_W'(mode_cfg));
        end else begin
            row_cfg = random_dim();
            col_cfg = $urandom_range(0, 1) ? row_cfg : random_dim();
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_ROW_COUNT, row_cfg);
                write_reg(CFG_COL_COUNT, col_cfg);
            end else begin
                write_reg(CFG_COL_COUNT, col_cfg);
                write_reg(CFG_ROW_COUNT, row_cfg);
            end
            write_reg(CFG_OP_MODE, CFG_W'(mode_cfg));
            cur_rows = effective_dim(row_cfg);
            cur_cols = effective_dim(col_cfg);
            loads = 2 * cur_rows * cur_cols;
            if ($urandom_range(0, 9) == 0) loads = $urandom_range(0, loads - 1);
        end
        total = cur_rows * cur_cols;
        for (int idx = 0; idx < loads; idx++) begin
            if ($urandom_range(0, 19) == 0) send_request(ACT_FETCH, random_element());
            send_request(ACT_LOAD, random_element());
        end
        fetches = $urandom_range(1, (2 * total + 1 < FETCH_RUN_CAP) ? 2 * total + 1 : FETCH_RUN_CAP);
        for (int idx = 0; idx < fetches; idx++) begin
            if ($urandom_range(0, 19) == 0) send_request(ACT_LOAD, random_element());
            send_request(ACT_FETCH, random_element());
        end
        wait_for_results();
    endtask

    initial begin
        int random_goal;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed part. Reset leaves a 1x1 add. A fetch before anything is
        // loaded, and one with only A loaded, must both come back as errors.
        send_request(ACT_FETCH, '0);
        send_request(ACT_LOAD, ELEM_MAX);
        send_request(ACT_FETCH, '1);
        send_request(ACT_LOAD, 1);
        // A load past both matrices is dropped. The add wraps to the most
        // negative value, and a second fetch starts the result over.
        send_request(ACT_LOAD, ELEM_MIN);
        send_request(ACT_FETCH, '0);
        send_request(ACT_FETCH, '0);
        wait_for_results();

        // Every mode on the same 1x1 data, then an unknown mode.
        write_reg(CFG_OP_MODE, CFG_W'(MODE_SUB));
        send_request(ACT_FETCH, '0);
        wait_for_results();
        write_reg(CFG_OP_MODE, CFG_W'(MODE_MUL));
        send_request(ACT_FETCH, '0);
        wait_for_results();
        write_reg(CFG_OP_MODE, CFG_W'(MODE_TRA));
        send_request(ACT_FETCH, '0);
        wait_for_results();
        write_reg(CFG_OP_MODE, CFG_W'(MODE_TRB));
        send_request(ACT_FETCH, '0);
        wait_for_results();
        write_reg(CFG_OP_MODE, CFG_W'(MODE_TRB + 1));
        send_request(ACT_FETCH, '0);
        wait_for_results();

        // A 2x1 multiply is not square and must fail; transposing B of the
        // same data gives a 1x2 row that wraps after its last element.
        write_reg(CFG_OP_MODE, CFG_W'(MODE_MUL));
        write_reg(CFG_ROW_COUNT, CFG_W'(2));
        send_request(ACT_LOAD, ELEM_MIN);
        send_request(ACT_LOAD, '1);
        send_request(ACT_LOAD, '0);
        send_request(ACT_LOAD, ELEM_MAX);
        send_request(ACT_FETCH, '0);
        wait_for_results();
        write_reg(CFG_OP_MODE, CFG_W'(MODE_TRB));
        send_request(ACT_FETCH, '0);
        send_request(ACT_FETCH, '0);
        send_request(ACT_FETCH, '0);
        wait_for_results();

        // Zero sizes fold to 1x1, and the size write restarts loading.
        write_reg(CFG_ROW_COUNT, '0);
        write_reg(CFG_COL_COUNT, '0);
        send_request(ACT_FETCH, '0);
        send_request(ACT_LOAD, '1);
        send_request(ACT_LOAD, '1);
        send_request(ACT_FETCH, '0);
        wait_for_results();

        // The largest size: an oversized row count folds to MAX_DIM, giving a
        // full square multiply with the longest accumulation, then a
        // transpose of the same data.
        write_reg(CFG_ROW_COUNT, '1);
        write_reg(CFG_COL_COUNT, CFG_W'(MAX_DIM));
        write_reg(CFG_OP_MODE, CFG_W'(MODE_MUL));
        cur_rows = MAX_DIM;
        cur_cols = MAX_DIM;
        for (int idx = 0; idx < 2 * MAX_DIM * MAX_DIM; idx++) begin
            send_request(ACT_LOAD, random_element());
        end
        for (int idx = 0; idx < 24; idx++) send_request(ACT_FETCH, '0);
        wait_for_results();
        write_reg(CFG_OP_MODE, CFG_W'(MODE_TRA));
        for (int idx = 0; idx < 24; idx++) send_request(ACT_FETCH, '0);
        wait_for_results();

        // Random phases until enough requests have gone through.
        random_goal = requests_sent + RANDOM_REQUESTS;
        while (requests_sent < random_goal) run_random_phase();

        wait_for_results();
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/sme_pkg.sv
rtl/sme_ram.sv
rtl/small_matrix_operation_engine_top.sv
tb/sme_result_checker.sv
tb/small_matrix_operation_engine_top_tb.sv
